[hw/rtl/sha256_pkg.sv]
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumH    = 8;
  localparam int unsigned NumW    = 16;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned HIdxW   = $clog2(NumH);
  localparam int unsigned WCntW   = $clog2(NumW);
  localparam int unsigned RndW    = $clog2(NumRnd);

  localparam logic       REQ_LOAD  = 1'b0;
  localparam logic       REQ_MSG   = 1'b1;
  localparam logic [WCntW-1:0] LAST_WORD_IDX = WCntW'(NumW - 1);
  localparam logic [RndW-1:0]  LAST_RND      = RndW'(NumRnd - 1);
  localparam logic [HIdxW-1:0] LAST_H_IDX    = HIdxW'(NumH - 1);

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } ctrl_st_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_chain;
    logic [HIdxW-1:0] load_idx;
    logic             shift_msg;
    logic             start;
    logic             round;
    logic [RndW-1:0]  rnd_idx;
    logic             final_add;
    logic [HIdxW-1:0] emit_idx;
  } dp_cmd_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_const(input logic [RndW-1:0] t);
    unique case (t)
      6'd0:  round_const = 32'h428a2f98;
      6'd1:  round_const = 32'h71374491;
      6'd2:  round_const = 32'hb5c0fbcf;
      6'd3:  round_const = 32'he9b5dba5;
      6'd4:  round_const = 32'h3956c25b;
      6'd5:  round_const = 32'h59f111f1;
      6'd6:  round_const = 32'h923f82a4;
      6'd7:  round_const = 32'hab1c5ed5;
      6'd8:  round_const = 32'hd807aa98;
      6'd9:  round_const = 32'h12835b01;
      6'd10: round_const = 32'h243185be;
      6'd11: round_const = 32'h550c7dc3;
      6'd12: round_const = 32'h72be5d74;
      6'd13: round_const = 32'h80deb1fe;
      6'd14: round_const = 32'h9bdc06a7;
      6'd15: round_const = 32'hc19bf174;
      6'd16: round_const = 32'he49b69c1;
      6'd17: round_const = 32'hefbe4786;
      6'd18: round_const = 32'h0fc19dc6;
      6'd19: round_const = 32'h240ca1cc;
      6'd20: round_const = 32'h2de92c6f;
      6'd21: round_const = 32'h4a7484aa;
      6'd22: round_const = 32'h5cb0a9dc;
      6'd23: round_const = 32'h76f988da;
      6'd24: round_const = 32'h983e5152;
      6'd25: round_const = 32'ha831c66d;
      6'd26: round_const = 32'hb00327c8;
      6'd27: round_const = 32'hbf597fc7;
      6'd28: round_const = 32'hc6e00bf3;
      6'd29: round_const = 32'hd5a79147;
      6'd30: round_const = 32'h06ca6351;
      6'd31: round_const = 32'h14292967;
      6'd32: round_const = 32'h27b70a85;
      6'd33: round_const = 32'h2e1b2138;
      6'd34: round_const = 32'h4d2c6dfc;
      6'd35: round_const = 32'h53380d13;
      6'd36: round_const = 32'h650a7354;
      6'd37: round_const = 32'h766a0abb;
      6'd38: round_const = 32'h81c2c92e;
      6'd39: round_const = 32'h92722c85;
      6'd40: round_const = 32'ha2bfe8a1;
      6'd41: round_const = 32'ha81a664b;
      6'd42: round_const = 32'hc24b8b70;
      6'd43: round_const = 32'hc76c51a3;
      6'd44: round_const = 32'hd192e819;
      6'd45: round_const = 32'hd6990624;
      6'd46: round_const = 32'hf40e3585;
      6'd47: round_const = 32'h106aa070;
      6'd48: round_const = 32'h19a4c116;
      6'd49: round_const = 32'h1e376c08;
      6'd50: round_const = 32'h2748774c;
      6'd51: round_const = 32'h34b0bcb5;
      6'd52: round_const = 32'h391c0cb3;
      6'd53: round_const = 32'h4ed8aa4a;
      6'd54: round_const = 32'h5b9cca4f;
      6'd55: round_const = 32'h682e6ff3;
      6'd56: round_const = 32'h748f82ee;
      6'd57: round_const = 32'h78a5636f;
      6'd58: round_const = 32'h84c87814;
      6'd59: round_const = 32'h8cc70208;
      6'd60: round_const = 32'h90befffa;
      6'd61: round_const = 32'ha4506ceb;
      6'd62: round_const = 32'hbef9a3f7;
      6'd63: round_const = 32'hc67178f2;
      default: round_const = '0;
    endcase
  endfunction

endpackage

[hw/rtl/sha256_in_if.sv]
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [2:0]  load_index;
  logic [31:0] data_word;
  logic        last_word;

  modport source (output valid, req_type, load_index, data_word, last_word, input ready);
  modport sink   (input valid, req_type, load_index, data_word, last_word, output ready);
endinterface

[hw/rtl/sha256_out_if.sv]
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_index;
  logic [31:0] state_word;
  logic        last;

  modport source (output valid, out_index, state_word, last, input ready);
  modport sink   (input valid, out_index, state_word, last, output ready);
endinterface

[hw/rtl/sha256_ctrl.sv]
module sha256_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_req_type_i,
  input  logic [sha256_pkg::HIdxW-1:0] in_load_index_i,
  input  logic                        in_last_word_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sha256_pkg::HIdxW-1:0] out_index_o,
  output logic                        out_last_o,
  output sha256_pkg::dp_cmd_t         cmd_o
);
  import sha256_pkg::*;

  ctrl_st_e         state_q, state_d;
  logic [WCntW-1:0] word_cnt_q, word_cnt_d;
  logic [RndW-1:0]  rnd_q, rnd_d;
  logic [HIdxW-1:0] emit_q, emit_d;
  logic             last_q, last_d;
  logic             in_acc, msg_acc, block_done, out_acc;

  assign in_acc     = in_valid_i && in_ready_o;
  assign msg_acc    = in_acc && (in_req_type_i == REQ_MSG);
  assign block_done = msg_acc && (word_cnt_q == LAST_WORD_IDX);
  assign out_acc    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (block_done) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == LAST_RND) state_d = ST_FINAL;
      ST_FINAL: state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_acc && (emit_q == LAST_H_IDX)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    out_valid_o      = (state_q == ST_EMIT);
    out_index_o      = emit_q;
    out_last_o       = (emit_q == LAST_H_IDX);
    cmd_o            = '0;
    cmd_o.load_chain = in_acc && (in_req_type_i == REQ_LOAD);
    cmd_o.load_idx   = in_load_index_i;
    cmd_o.shift_msg  = msg_acc;
    cmd_o.start      = block_done;
    cmd_o.round      = (state_q == ST_ROUND);
    cmd_o.rnd_idx    = rnd_q;
    cmd_o.final_add  = (state_q == ST_FINAL);
    cmd_o.emit_idx   = emit_q;
  end

  always_comb begin
    word_cnt_d = word_cnt_q;
    rnd_d      = rnd_q;
    emit_d     = emit_q;
    last_d     = last_q;
    if (msg_acc) word_cnt_d = word_cnt_q + 1'b1;  // wraps to zero after the 16th word
    if (block_done) begin
      last_d = in_last_word_i;
      rnd_d  = '0;
    end
    if (state_q == ST_ROUND) rnd_d = rnd_q + 1'b1;
    if (state_q == ST_FINAL) emit_d = '0;
    if (out_acc) emit_d = emit_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      word_cnt_q <= '0;
      rnd_q      <= '0;
      emit_q     <= '0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_cnt_q <= word_cnt_d;
      rnd_q      <= rnd_d;
      emit_q     <= emit_d;
      last_q     <= last_d;
    end
  end

endmodule

[hw/rtl/sha256_dp.sv]
module sha256_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256_pkg::dp_cmd_t cmd_i,
  input  sha256_pkg::word_t   data_word_i,
  output sha256_pkg::word_t   state_word_o
);
  import sha256_pkg::*;

  word_t chain_q [NumH];
  word_t work_q  [NumH];
  word_t win_q   [NumW];

  word_t w_exp, w_t, t1, t2, ch, maj, win_in;

  // Rolling window: win_q[0] is the oldest word, win_q[15] the newest.
  assign w_exp = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];
  assign w_t   = (cmd_i.rnd_idx < RndW'(NumW)) ? win_q[0] : w_exp;

  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + big_sig1(work_q[4]) + ch + round_const(cmd_i.rnd_idx) + w_t;
  assign t2  = big_sig0(work_q[0]) + maj;

  // Early rounds rotate the window so it holds W0..W15 again at round 16.
  assign win_in = cmd_i.round ? w_t : data_word_i;

  assign state_word_o = chain_q[cmd_i.emit_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumH; i++) chain_q[i] <= '0;
    end else begin
      if (cmd_i.load_chain) chain_q[cmd_i.load_idx] <= data_word_i;
      if (cmd_i.final_add) begin
        for (int i = 0; i < NumH; i++) chain_q[i] <= chain_q[i] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_msg || cmd_i.round) begin
      for (int i = 0; i < NumW - 1; i++) win_q[i] <= win_q[i+1];
      win_q[NumW-1] <= win_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < NumH; i++) work_q[i] <= chain_q[i];
    end else if (cmd_i.round) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

endmodule

[hw/rtl/sha256_block_compress.sv]
// Channel  Dir  Payload                                     Role
// req_i    in   req_type, load_index, data_word, last_word  chaining load or message word
// rsp_o    out  out_index, state_word, last                 updated chaining words H0..H7
//
// A load or a message word is accepted only in the idle state. The sixteenth
// message word starts 64 rounds at one per cycle in the datapath, then the
// final add folds the working state into the chaining value.
// After a block marked last, eight words go out at one per cycle while rsp_o
// is ready; req_i is held off until the eighth is taken.
// Reset clears the chaining value and all counters.
module sha256_block_compress (
  input logic          clk_i,
  input logic          rst_ni,
  sha256_in_if.sink    req_i,
  sha256_out_if.source rsp_o
);
  import sha256_pkg::*;

  dp_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req_i.valid),
    .in_req_type_i   (req_i.req_type),
    .in_load_index_i (req_i.load_index),
    .in_last_word_i  (req_i.last_word),
    .in_ready_o      (req_i.ready),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .out_index_o     (rsp_o.out_index),
    .out_last_o      (rsp_o.last),
    .cmd_o           (cmd)
  );

  sha256_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_word_i  (req_i.data_word),
    .state_word_o (rsp_o.state_word)
  );

endmodule

[hw/rtl/sha256_checker.sv]
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_index_i,
  input logic [31:0] state_word_i,
  input logic        out_last_i
);

  // Hold a stalled word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(state_word_i) && $stable(out_index_i))
    else $error("stalled output word changed");

  // No input is taken while words are going out.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while emitting");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == 3'd7)))
    else $error("last mark not on index 7");

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i &&
      (out_index_i == $past(out_index_i) + 3'd1))
    else $error("output words out of order");

  // An accepted word never causes an output in the very next cycle.
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("output right after input");

endmodule

bind sha256_block_compress sha256_checker u_sha256_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_index_i  (rsp_o.out_index),
  .state_word_i (rsp_o.state_word),
  .out_last_i   (rsp_o.last)
);
